// File: src/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotator.
package qvr_pkg;

	localparam int Q_W = 16;
	localparam int V_W = 16;
	localparam int O_W = 17;
	localparam int T_W = 33;
	localparam int P_W = 49;
	localparam int R_W = 51;
	localparam int REG_IDX_W = 2;

	localparam logic signed [Q_W-1:0] ROT_REAL_RST = 16'sh7FFF;
	localparam logic signed [Q_W-1:0] ROT_IMAG_RST = 16'sh0000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROT_REAL = 2'd0,
		REG_ROT_I    = 2'd1,
		REG_ROT_J    = 2'd2,
		REG_ROT_K    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [Q_W-1:0] re;
		logic signed [Q_W-1:0] i;
		logic signed [Q_W-1:0] j;
		logic signed [Q_W-1:0] k;
	} quat_t;

	typedef struct packed {
		logic signed [T_W-1:0] tr;
		logic signed [T_W-1:0] ti;
		logic signed [T_W-1:0] tj;
		logic signed [T_W-1:0] tk;
	} tquat_t;

	typedef struct packed {
		logic signed [R_W-1:0] ri;
		logic signed [R_W-1:0] rj;
		logic signed [R_W-1:0] rk;
	} rvec_t;

endpackage

// File: src/qvr_if.sv
// Channel interfaces: vector requests, rotated results, register writes.
interface qvr_vec_if;
	logic                                valid;
	logic                                ready;
	logic signed [qvr_pkg::V_W-1:0]      vec_x;
	logic signed [qvr_pkg::V_W-1:0]      vec_y;
	logic signed [qvr_pkg::V_W-1:0]      vec_z;

	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [qvr_pkg::O_W-1:0]      out_x;
	logic signed [qvr_pkg::O_W-1:0]      out_y;
	logic signed [qvr_pkg::O_W-1:0]      out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface qvr_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [qvr_pkg::REG_IDX_W-1:0]       index;
	logic [qvr_pkg::Q_W-1:0]             data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/quaternion_vector_rotator_core.sv
// Top level: rotation registers and the five-stage q*v*conj(q) pipeline.
//
//   channel  dir  payload                    width
//   vec      in   vec_x, vec_y, vec_z        3 x 16 signed
//   res      out  out_x, out_y, out_z        3 x 17 signed
//   cfg      in   index, data                2 + 16
//
// An accepted request passes through the stages in order and its result leaves
// from the output register; one request per cycle is taken while the output is
// not stalled. Stages: q*v products, q*v sums, t*conj(q) products, sums, round
// and saturate into the output register. Each stage advances when its successor
// is empty or moving, so a stall backs up without loss. Reset clears valid bits
// and sets q to (32767, 0, 0, 0); cfg is always ready.
module quaternion_vector_rotator_core (
	input  logic          clk,
	input  logic          arst_n,
	qvr_vec_if.sink       vec,
	qvr_res_if.source     res,
	qvr_cfg_if.sink       cfg
);

	qvr_pkg::quat_t  rot_q;
	qvr_pkg::tquat_t t;
	qvr_pkg::rvec_t  r;
	logic            t_valid, t_ready, r_valid, r_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.re <= qvr_pkg::ROT_REAL_RST;
			rot_q.i  <= qvr_pkg::ROT_IMAG_RST;
			rot_q.j  <= qvr_pkg::ROT_IMAG_RST;
			rot_q.k  <= qvr_pkg::ROT_IMAG_RST;
		end else if (cfg.valid) begin
			unique case (qvr_pkg::reg_idx_t'(cfg.index))
				qvr_pkg::REG_ROT_REAL: rot_q.re <= $signed(cfg.data);
				qvr_pkg::REG_ROT_I:    rot_q.i  <= $signed(cfg.data);
				qvr_pkg::REG_ROT_J:    rot_q.j  <= $signed(cfg.data);
				qvr_pkg::REG_ROT_K:    rot_q.k  <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	qvr_fwd u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.rot       (rot_q),
		.in_valid  (vec.valid),
		.in_ready  (vec.ready),
		.x         (vec.vec_x),
		.y         (vec.vec_y),
		.z         (vec.vec_z),
		.out_valid (t_valid),
		.out_ready (t_ready),
		.t         (t)
	);

	qvr_conj u_conj (
		.clk       (clk),
		.arst_n    (arst_n),
		.rot       (rot_q),
		.in_valid  (t_valid),
		.in_ready  (t_ready),
		.t         (t),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.r         (r)
	);

	qvr_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.r         (r),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.ox        (res.out_x),
		.oy        (res.out_y),
		.oz        (res.out_z)
	);

endmodule

// File: src/qvr_fwd.sv
// First Hamilton product t = q * (0, v): product stage then sum stage.
module qvr_fwd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qvr_pkg::quat_t                rot,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [qvr_pkg::V_W-1:0] x,
	input  logic signed [qvr_pkg::V_W-1:0] y,
	input  logic signed [qvr_pkg::V_W-1:0] z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output qvr_pkg::tquat_t               t
);

	localparam int PW = 2 * qvr_pkg::Q_W;
	localparam int TW = qvr_pkg::T_W;

	logic signed [qvr_pkg::Q_W-1:0] qr, qi, qj, qk;
	logic                           v_s1, v_s2, en1, en2;
	logic signed [PW-1:0] ix_s1, jy_s1, kz_s1, rx_s1, jz_s1, ky_s1;
	logic signed [PW-1:0] ry_s1, kx_s1, iz_s1, rz_s1, iy_s1, jx_s1;
	qvr_pkg::tquat_t t_s2;

	assign qr = rot.re;
	assign qi = rot.i;
	assign qj = rot.j;
	assign qk = rot.k;

	assign en2       = !v_s2 || out_ready;
	assign en1       = !v_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = v_s2;
	assign t         = t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ix_s1 <= qi * x;
			jy_s1 <= qj * y;
			kz_s1 <= qk * z;
			rx_s1 <= qr * x;
			jz_s1 <= qj * z;
			ky_s1 <= qk * y;
			ry_s1 <= qr * y;
			kx_s1 <= qk * x;
			iz_s1 <= qi * z;
			rz_s1 <= qr * z;
			iy_s1 <= qi * y;
			jx_s1 <= qj * x;
		end
		if (en2 && v_s1) begin
			t_s2.tr <= -TW'(ix_s1) - TW'(jy_s1) - TW'(kz_s1);
			t_s2.ti <= TW'(rx_s1) + TW'(jz_s1) - TW'(ky_s1);
			t_s2.tj <= TW'(ry_s1) + TW'(kx_s1) - TW'(iz_s1);
			t_s2.tk <= TW'(rz_s1) + TW'(iy_s1) - TW'(jx_s1);
		end
	end

endmodule

// File: src/qvr_conj.sv
// Second Hamilton product t * conj(q), vector part: product stage then sum stage.
module qvr_conj (
	input  logic            clk,
	input  logic            arst_n,
	input  qvr_pkg::quat_t  rot,
	input  logic            in_valid,
	output logic            in_ready,
	input  qvr_pkg::tquat_t t,
	output logic            out_valid,
	input  logic            out_ready,
	output qvr_pkg::rvec_t  r
);

	localparam int PW = qvr_pkg::P_W;
	localparam int RW = qvr_pkg::R_W;

	logic signed [qvr_pkg::Q_W-1:0] qr, qi, qj, qk;
	logic signed [qvr_pkg::T_W-1:0] tr, ti, tj, tk;
	logic                           v_s1, v_s2, en1, en2;
	logic signed [PW-1:0] ri_a_s1, ri_b_s1, ri_c_s1, ri_d_s1;
	logic signed [PW-1:0] rj_a_s1, rj_b_s1, rj_c_s1, rj_d_s1;
	logic signed [PW-1:0] rk_a_s1, rk_b_s1, rk_c_s1, rk_d_s1;
	qvr_pkg::rvec_t r_s2;

	assign qr = rot.re;
	assign qi = rot.i;
	assign qj = rot.j;
	assign qk = rot.k;
	assign tr = t.tr;
	assign ti = t.ti;
	assign tj = t.tj;
	assign tk = t.tk;

	assign en2       = !v_s2 || out_ready;
	assign en1       = !v_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = v_s2;
	assign r         = r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ri_a_s1 <= tr * qi;
			ri_b_s1 <= ti * qr;
			ri_c_s1 <= tj * qk;
			ri_d_s1 <= tk * qj;
			rj_a_s1 <= tr * qj;
			rj_b_s1 <= tj * qr;
			rj_c_s1 <= tk * qi;
			rj_d_s1 <= ti * qk;
			rk_a_s1 <= tr * qk;
			rk_b_s1 <= tk * qr;
			rk_c_s1 <= ti * qj;
			rk_d_s1 <= tj * qi;
		end
		if (en2 && v_s1) begin
			r_s2.ri <= RW'(ri_b_s1) - RW'(ri_a_s1) - RW'(ri_c_s1) + RW'(ri_d_s1);
			r_s2.rj <= RW'(rj_b_s1) - RW'(rj_a_s1) - RW'(rj_c_s1) + RW'(rj_d_s1);
			r_s2.rk <= RW'(rk_b_s1) - RW'(rk_a_s1) - RW'(rk_c_s1) + RW'(rk_d_s1);
		end
	end

endmodule

// File: src/qvr_round.sv
// Round to nearest (ties up), drop 30 fraction bits, saturate, output register.
module qvr_round (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  qvr_pkg::rvec_t                  r,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [qvr_pkg::O_W-1:0]  ox,
	output logic signed [qvr_pkg::O_W-1:0]  oy,
	output logic signed [qvr_pkg::O_W-1:0]  oz
);

	localparam int RW = qvr_pkg::R_W;
	localparam int OW = qvr_pkg::O_W;
	localparam int FRAC = 30;
	localparam int SW = RW - FRAC;
	localparam logic signed [RW-1:0] HALF = RW'(64'sd1 <<< (FRAC - 1));
	localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (OW - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(-(64'sd1 <<< (OW - 1)));

	function automatic logic signed [OW-1:0] rnd_sat(input logic signed [RW-1:0] acc);
		logic signed [RW-1:0] biased;
		logic signed [SW-1:0] whole;
		biased = acc + HALF;
		whole  = $signed(biased[RW-1:FRAC]);
		if (whole > SAT_MAX) begin
			return OW'(SAT_MAX);
		end else if (whole < SAT_MIN) begin
			return OW'(SAT_MIN);
		end
		return OW'(whole);
	endfunction

	logic v_s1, en1;
	logic signed [OW-1:0] ox_s1, oy_s1, oz_s1;

	assign en1       = !v_s1 || out_ready;
	assign in_ready  = en1;
	assign out_valid = v_s1;
	assign ox        = ox_s1;
	assign oy        = oy_s1;
	assign oz        = oz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ox_s1 <= rnd_sat(r.ri);
			oy_s1 <= rnd_sat(r.rj);
			oz_s1 <= rnd_sat(r.rk);
		end
	end

endmodule

// File: tb/sv/tb_quaternion_vector_rotator_core.sv
// Self-checking testbench for the quaternion vector rotator core.
module tb_quaternion_vector_rotator_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [qvr_pkg::O_W-1:0] x;
		logic signed [qvr_pkg::O_W-1:0] y;
		logic signed [qvr_pkg::O_W-1:0] z;
	} rotated_t;

	typedef struct {
		bit                             load_q;
		qvr_pkg::quat_t                 q;
		logic signed [qvr_pkg::V_W-1:0] x;
		logic signed [qvr_pkg::V_W-1:0] y;
		logic signed [qvr_pkg::V_W-1:0] z;
		bit                             typed;
		rotated_t                       want;
	} dir_row_t;

	typedef enum int {PICK_FULL, PICK_HALF, PICK_EDGE, PICK_SMALL} pick_mode_t;

	localparam int RANDOM_ITEMS   = 700;
	localparam int CALM_AFTER     = 600;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 8;

	localparam logic signed [qvr_pkg::V_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [qvr_pkg::V_W-1:0] S_MIN = 16'sh8000;

	localparam rotated_t NO_WANT = '0;
	localparam qvr_pkg::quat_t Q_KEEP        = '0;
	localparam qvr_pkg::quat_t Q_ZERO        = '0;
	localparam qvr_pkg::quat_t Q_NEG_UNIT    = '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000};
	localparam qvr_pkg::quat_t Q_HALF_TURN_X = '{16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000};
	localparam qvr_pkg::quat_t Q_ALL_MIN     = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
	localparam qvr_pkg::quat_t Q_QUARTER_Z   = '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170};
	localparam qvr_pkg::quat_t Q_CYCLE_XYZ   = '{16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000};
	localparam qvr_pkg::quat_t Q_MIXED       = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000};

	// reset q scales by (32767/32768)^2; -32768 real part is an exact identity;
	// all-min q has squared norm 4 and saturates; 0.5*(1,1,1,1) cycles x -> y -> z
	dir_row_t dir_tab [20] = '{
		'{1'b0, Q_KEEP, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{17'sd0, 17'sd0, 17'sd0}},
		'{1'b0, Q_KEEP, S_MAX, S_MAX, S_MAX, 1'b1,
			'{17'sd32765, 17'sd32765, 17'sd32765}},
		'{1'b0, Q_KEEP, S_MIN, S_MIN, S_MIN, 1'b1,
			'{-17'sd32766, -17'sd32766, -17'sd32766}},
		'{1'b0, Q_KEEP, 16'sd1, -16'sd1, 16'sd0, 1'b1, '{17'sd1, -17'sd1, 17'sd0}},
		'{1'b0, Q_KEEP, 16'sd12345, -16'sd23456, 16'sd7, 1'b0, NO_WANT},
		'{1'b1, Q_NEG_UNIT, S_MAX, S_MIN, 16'sd0, 1'b1,
			'{17'sd32767, -17'sd32768, 17'sd0}},
		'{1'b0, Q_KEEP, -16'sd1, 16'sd1, S_MAX, 1'b1, '{-17'sd1, 17'sd1, 17'sd32767}},
		'{1'b1, Q_HALF_TURN_X, S_MAX, S_MIN, S_MAX, 1'b1,
			'{17'sd32767, 17'sd32768, -17'sd32767}},
		'{1'b0, Q_KEEP, S_MIN, S_MAX, S_MIN, 1'b1,
			'{-17'sd32768, -17'sd32767, 17'sd32768}},
		'{1'b1, Q_ALL_MIN, S_MAX, S_MAX, S_MAX, 1'b1,
			'{17'sd65535, 17'sd65535, 17'sd65535}},
		'{1'b0, Q_KEEP, S_MIN, S_MIN, S_MIN, 1'b1,
			'{17'sh10000, 17'sh10000, 17'sh10000}},
		'{1'b0, Q_KEEP, 16'sd1000, -16'sd2000, 16'sd3000, 1'b0, NO_WANT},
		'{1'b1, Q_ZERO, S_MAX, S_MIN, 16'sd12345, 1'b1, '{17'sd0, 17'sd0, 17'sd0}},
		'{1'b1, Q_QUARTER_Z, 16'sd10000, 16'sd0, 16'sd0, 1'b0, NO_WANT},
		'{1'b0, Q_KEEP, 16'sd0, 16'sd10000, -16'sd5000, 1'b0, NO_WANT},
		'{1'b0, Q_KEEP, S_MIN, S_MAX, S_MIN, 1'b0, NO_WANT},
		'{1'b1, Q_CYCLE_XYZ, 16'sd100, -16'sd200, 16'sd300, 1'b1,
			'{17'sd300, 17'sd100, -17'sd200}},
		'{1'b0, Q_KEEP, S_MAX, S_MIN, 16'sd1, 1'b1,
			'{17'sd1, 17'sd32767, -17'sd32768}},
		'{1'b1, Q_MIXED, S_MAX, S_MIN, S_MAX, 1'b0, NO_WANT},
		'{1'b0, Q_KEEP, -16'sd1, -16'sd1, -16'sd1, 1'b0, NO_WANT}
	};

	logic clk;
	logic arst_n;

	qvr_vec_if vec_ch();
	qvr_res_if res_ch();
	qvr_cfg_if cfg_ch();

	quaternion_vector_rotator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	qvr_pkg::quat_t rot_q;
	rotated_t       rotated_q [$];
	rotated_t       got;
	rotated_t       want;
	bit             pend_typed;
	rotated_t       pend_want;
	bit             calm;
	int             mismatches;
	int             idle_cycles;

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [qvr_pkg::O_W-1:0] round_sat(input longint acc);
		longint v;
		v = (acc + 64'sd536870912) >>> 30;
		if (v > 64'sd65535)
			v = 64'sd65535;
		if (v < -64'sd65536)
			v = -64'sd65536;
		return v[qvr_pkg::O_W-1:0];
	endfunction

	// q * (0, v) * conj(q), exact, then round and saturate each component
	function automatic rotated_t rotate_vector(input qvr_pkg::quat_t q,
			input logic signed [qvr_pkg::V_W-1:0] x, y, z);
		longint qr, qi, qj, qk, vx, vy, vz;
		longint tr, ti, tj, tk;
		rotated_t r;
		qr = longint'($signed(q.re));
		qi = longint'($signed(q.i));
		qj = longint'($signed(q.j));
		qk = longint'($signed(q.k));
		vx = longint'(x);
		vy = longint'(y);
		vz = longint'(z);
		tr = -qi * vx - qj * vy - qk * vz;
		ti = qr * vx + qj * vz - qk * vy;
		tj = qr * vy + qk * vx - qi * vz;
		tk = qr * vz + qi * vy - qj * vx;
		r.x = round_sat(-tr * qi + ti * qr - tj * qk + tk * qj);
		r.y = round_sat(-tr * qj + tj * qr - tk * qi + ti * qk);
		r.z = round_sat(-tr * qk + tk * qr - ti * qj + tj * qi);
		return r;
	endfunction

	function automatic logic signed [qvr_pkg::V_W-1:0] pick_comp(input pick_mode_t mode);
		int r;
		case (mode)
			PICK_FULL: r = int'($urandom_range(0, 65535)) - 32768;
			PICK_HALF: r = int'($urandom_range(0, 32768)) - 16384;
			PICK_SMALL: r = int'($urandom_range(0, 600)) - 300;
			default: begin
				case ($urandom_range(0, 4))
					0: r = -32768;
					1: r = 32767;
					2: r = -1;
					3: r = 1;
					default: r = 0;
				endcase
			end
		endcase
		return r[qvr_pkg::V_W-1:0];
	endfunction

	task automatic send_vector(input logic signed [qvr_pkg::V_W-1:0] x, y, z,
			input bit typed, input rotated_t w);
		@(negedge clk);
		vec_ch.valid = 1'b1;
		vec_ch.vec_x = x;
		vec_ch.vec_y = y;
		vec_ch.vec_z = z;
		pend_typed = typed;
		pend_want = w;
		do @(posedge clk); while (!vec_ch.ready);
	endtask

	task automatic drain;
		@(negedge clk);
		vec_ch.valid = 1'b0;
		while (rotated_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input qvr_pkg::reg_idx_t idx,
			input logic [qvr_pkg::Q_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = d;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_rotation(input qvr_pkg::quat_t q);
		drain();
		cfg_write(qvr_pkg::REG_ROT_REAL, q.re);
		cfg_write(qvr_pkg::REG_ROT_I, q.i);
		cfg_write(qvr_pkg::REG_ROT_J, q.j);
		cfg_write(qvr_pkg::REG_ROT_K, q.k);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// model state, expected results and result checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.re = qvr_pkg::ROT_REAL_RST;
			rot_q.i = qvr_pkg::ROT_IMAG_RST;
			rot_q.j = qvr_pkg::ROT_IMAG_RST;
			rot_q.k = qvr_pkg::ROT_IMAG_RST;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					qvr_pkg::REG_ROT_REAL: rot_q.re = cfg_ch.data;
					qvr_pkg::REG_ROT_I: rot_q.i = cfg_ch.data;
					qvr_pkg::REG_ROT_J: rot_q.j = cfg_ch.data;
					qvr_pkg::REG_ROT_K: rot_q.k = cfg_ch.data;
					default: ;
				endcase
			end
			if (vec_ch.valid && vec_ch.ready)
				rotated_q.push_back(pend_typed ? pend_want :
					rotate_vector(rot_q, vec_ch.vec_x, vec_ch.vec_y, vec_ch.vec_z));
			if (res_ch.valid && res_ch.ready) begin
				got.x = res_ch.out_x;
				got.y = res_ch.out_y;
				got.z = res_ch.out_z;
				if (rotated_q.size() == 0) begin
					$error("result with no request pending: %0d %0d %0d",
						got.x, got.y, got.z);
					mismatches++;
				end else begin
					want = rotated_q.pop_front();
					if (got.x !== want.x) begin
						$error("out_x: expected %0d, actual %0d", want.x, got.x);
						mismatches++;
					end
					if (got.y !== want.y) begin
						$error("out_y: expected %0d, actual %0d", want.y, got.y);
						mismatches++;
					end
					if (got.z !== want.z) begin
						$error("out_z: expected %0d, actual %0d", want.z, got.z);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// result back-pressure
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				res_ch.ready = 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	initial begin
		qvr_pkg::quat_t q;
		pick_mode_t q_mode;
		pick_mode_t v_mode;
		int phase_len;
		int sent;
		int r;

		arst_n = 1'b0;
		vec_ch.valid = 1'b0;
		vec_ch.vec_x = '0;
		vec_ch.vec_y = '0;
		vec_ch.vec_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = qvr_pkg::REG_ROT_REAL;
		cfg_ch.data = '0;
		pend_typed = 1'b0;
		pend_want = NO_WANT;
		calm = 1'b0;
		sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[n]) begin
			if (dir_tab[n].load_q)
				load_rotation(dir_tab[n].q);
			send_vector(dir_tab[n].x, dir_tab[n].y, dir_tab[n].z,
				dir_tab[n].typed, dir_tab[n].want);
		end

		// each phase drains and loads a fresh q (until calm is set), then streams vectors
		while (sent < RANDOM_ITEMS) begin
			if (!calm) begin
				q_mode = pick_mode_t'($urandom_range(0, 2));
				q.re = pick_comp(q_mode);
				q.i = pick_comp(q_mode);
				q.j = pick_comp(q_mode);
				q.k = pick_comp(q_mode);
				load_rotation(q);
			end
			phase_len = $urandom_range(40, 100);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				if (sent >= CALM_AFTER)
					calm = 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) begin
					@(negedge clk);
					vec_ch.valid = 1'b0;
					repeat ($urandom_range(0, 11)) @(negedge clk);
				end
				r = $urandom_range(0, 9);
				v_mode = (r < 6) ? PICK_FULL : (r < 8) ? PICK_SMALL : PICK_EDGE;
				send_vector(pick_comp(v_mode), pick_comp(v_mode), pick_comp(v_mode),
					1'b0, NO_WANT);
				sent++;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
